// File: hw/rtl/length_prefixed_segment_checker_unit_defines.svh
// ----------------------------------------------------------------------------
// Length-prefixed segment checker assertion macros
// Shared assertion forms for the checker of the segment checker unit.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_SEGMENT_CHECKER_UNIT_DEFINES_SVH
`define LENGTH_PREFIXED_SEGMENT_CHECKER_UNIT_DEFINES_SVH

// A condition that holds at every clock edge out of reset.
`define LPSC_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that, once seen, gives a consequence in the cycle after it.
`define LPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// A consequence that follows a cycle of reset.
`define LPSC_ASSERT_AFTER_RESET(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/lpsc_pkg.sv
// ----------------------------------------------------------------------------
// Length-prefixed segment checker package
// Types and constants shared by the segment checker modules.
// ----------------------------------------------------------------------------
package lpsc_pkg;

    localparam int MAX_SEGMENTS    = 6;
    localparam int MAX_TOTAL_BYTES = 65536;
    localparam int PREFIX_BYTES    = 4;

    localparam int SEG_W   = 3;
    localparam int LEN_W   = 17;
    localparam int ACC_W   = 8 * PREFIX_BYTES;
    localparam int PIDX_W  = $clog2(PREFIX_BYTES);
    localparam int TOTAL_W = $clog2(MAX_TOTAL_BYTES + 2);
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [SEG_W-1:0] REG_SEG_COUNT = 3'd0;
    localparam logic [SEG_W-1:0] REG_CHECK     = 3'd1;
    localparam logic [SEG_W-1:0] REG_EXP_A     = 3'd2;
    localparam logic [SEG_W-1:0] REG_EXP_B     = 3'd3;
    localparam logic [SEG_W-1:0] REG_EXP_C     = 3'd4;
    localparam logic [SEG_W-1:0] REG_EXP_D     = 3'd5;
    localparam logic [SEG_W-1:0] REG_EXP_E     = 3'd6;
    localparam logic [SEG_W-1:0] REG_EXP_F     = 3'd7;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_ARG = 2'd1,
        ST_FMT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'b001,
        PH_BODY   = 3'b010,
        PH_DONE   = 3'b100
    } t_phase;

    typedef struct packed {
        logic [SEG_W-1:0]                   seg_count;
        logic                               check_lengths;
        logic [MAX_SEGMENTS-1:0][LEN_W-1:0] exp_len;
    } t_cfg;

    typedef struct packed {
        t_status          status;
        logic [SEG_W-1:0] segments_seen;
    } t_result;

endpackage

// File: hw/rtl/lpsc_regs.sv
// ----------------------------------------------------------------------------
// Segment checker register file
// Configuration registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
module lpsc_regs import lpsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg             r_cfg;
    logic [SEG_W-1:0] reg_idx;
    logic [SEG_W-1:0] exp_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign exp_idx = reg_idx - REG_EXP_A;
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seg_count     <= SEG_W'(1);
            r_cfg.check_lengths <= 1'b0;
            for (int k = 0; k < MAX_SEGMENTS; k++) begin
                r_cfg.exp_len[k] <= LEN_W'(1);
            end
        end else if (wr_en) begin
            unique case (reg_idx) inside
                REG_SEG_COUNT: begin
                    r_cfg.seg_count <= pwdata[SEG_W-1:0];
                end
                REG_CHECK: begin
                    r_cfg.check_lengths <= pwdata[0];
                end
                REG_EXP_A, REG_EXP_B, REG_EXP_C, REG_EXP_D, REG_EXP_E, REG_EXP_F: begin
                    r_cfg.exp_len[exp_idx] <= pwdata[LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx) inside
            REG_SEG_COUNT: begin
                prdata = DATA_W'(r_cfg.seg_count);
            end
            REG_CHECK: begin
                prdata = DATA_W'(r_cfg.check_lengths);
            end
            REG_EXP_A, REG_EXP_B, REG_EXP_C, REG_EXP_D, REG_EXP_E, REG_EXP_F: begin
                prdata = DATA_W'(r_cfg.exp_len[exp_idx]);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/lpsc_parse.sv
// ----------------------------------------------------------------------------
// Segment checker parser
// Parse state for one buffer and the status of its final byte.
// ----------------------------------------------------------------------------
module lpsc_parse import lpsc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic [7:0] i_data,
    input  logic       i_last,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    t_phase              r_phase,  n_phase;
    logic [PIDX_W-1:0]   r_pidx,   n_pidx;
    logic [ACC_W-1:0]    r_acc,    n_acc;
    logic [ACC_W-1:0]    r_left,   n_left;
    logic [SEG_W-1:0]    r_seg,    n_seg;
    logic [TOTAL_W-1:0]  r_total,  n_total;
    logic                r_ferr,   n_ferr;
    logic [LEN_W-1:0]    exp_sel;
    logic                seg_cnt_bad;

    always_comb begin
        exp_sel = '0;
        for (int k = 0; k < MAX_SEGMENTS; k++) begin
            if (r_seg == SEG_W'(k)) begin
                exp_sel = i_cfg.exp_len[k];
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_pidx  = r_pidx;
        n_acc   = r_acc;
        n_left  = r_left;
        n_seg   = r_seg;
        n_ferr  = r_ferr;
        n_total = (r_total <= TOTAL_W'(MAX_TOTAL_BYTES)) ? r_total + TOTAL_W'(1) : r_total;

        unique case (r_phase)
            PH_PREFIX: begin
                n_acc = r_acc | (ACC_W'(i_data) << {r_pidx, 3'b000});
                if (r_pidx == PIDX_W'(PREFIX_BYTES - 1)) begin
                    n_pidx = '0;
                    n_left = n_acc;
                    n_acc  = '0;
                    if (r_seg != '1) begin
                        n_seg = r_seg + SEG_W'(1);
                    end
                    if (n_left == '0) begin
                        n_ferr  = 1'b1;
                        n_phase = (n_seg >= i_cfg.seg_count) ? PH_DONE : PH_PREFIX;
                    end else begin
                        n_phase = PH_BODY;
                    end
                    if (i_cfg.check_lengths && (r_seg < SEG_W'(MAX_SEGMENTS)) &&
                        (ACC_W'(exp_sel) != n_left)) begin
                        n_ferr = 1'b1;
                    end
                end else begin
                    n_pidx = r_pidx + PIDX_W'(1);
                end
            end
            PH_BODY: begin
                if (r_left != '0) begin
                    n_left = r_left - ACC_W'(1);
                end
                if (n_left == '0) begin
                    n_phase = (r_seg >= i_cfg.seg_count) ? PH_DONE : PH_PREFIX;
                end
            end
            PH_DONE: begin
                n_ferr = 1'b1;
            end
            default: begin
                n_phase = PH_PREFIX;
            end
        endcase
    end

    assign seg_cnt_bad = (i_cfg.seg_count == '0) ||
                         (i_cfg.seg_count > SEG_W'(MAX_SEGMENTS));

    always_comb begin
        o_result.segments_seen = n_seg;
        if (seg_cnt_bad || (n_total > TOTAL_W'(MAX_TOTAL_BYTES))) begin
            o_result.status = ST_ARG;
        end else if (n_ferr) begin
            o_result.status = ST_FMT;
        end else if ((n_phase == PH_PREFIX) && (n_pidx != '0)) begin
            o_result.status = ST_FMT;
        end else if ((n_phase == PH_BODY) && (n_left != '0)) begin
            o_result.status = ST_FMT;
        end else begin
            o_result.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_last)) begin
            r_phase <= PH_PREFIX;
            r_pidx  <= '0;
            r_acc   <= '0;
            r_left  <= '0;
            r_seg   <= '0;
            r_total <= '0;
            r_ferr  <= 1'b0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_pidx  <= n_pidx;
            r_acc   <= n_acc;
            r_left  <= n_left;
            r_seg   <= n_seg;
            r_total <= n_total;
            r_ferr  <= n_ferr;
        end
    end

endmodule

// File: hw/rtl/length_prefixed_segment_checker_unit.sv
// ----------------------------------------------------------------------------
// Length-prefixed segment checker unit
// Checks a buffer of length-prefixed segments, one byte per item, and gives
// one status item on the final byte.
// ----------------------------------------------------------------------------
// The block takes one byte item in every clock cycle, sustained while no final
// byte is held, and presents the status item from the result register: the
// final byte waits in the input register while the parse step updates the
// counters, assembles the four-byte little-endian length and makes its
// compares, and the result register takes the status when the byte advances. A
// result waiting in the output register does not stop byte items that carry
// no end-of-buffer flag; a final byte waits in the input register until the
// previous status item has been taken. Configuration is to be written only
// while no buffer is in progress.
module length_prefixed_segment_checker_unit import lpsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
    input  logic              s_axis_tlast,   // last_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [1:0] status, [4:2] segments_seen
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg       cfg;
    t_result    result;
    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    logic       advance;

    lpsc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lpsc_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_data    (r_in_data),
        .i_last    (r_in_last),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    assign advance       = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.segments_seen, r_out.status};

endmodule

// File: hw/rtl/lpsc_checker.sv
// ----------------------------------------------------------------------------
// Segment checker port checker
// Assertions on what the ports of the segment checker unit show over time.
// ----------------------------------------------------------------------------
`include "length_prefixed_segment_checker_unit_defines.svh"

module lpsc_checker import lpsc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       pready
);

    `LPSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled status item changed")

    `LPSC_ASSERT_HOLDS(a_status_code, i_clk, i_rst_n, !m_axis_tvalid || (m_axis_tdata[7:5] == 3'b000 && (m_axis_tdata[1:0] == ST_OK || m_axis_tdata[1:0] == ST_ARG || m_axis_tdata[1:0] == ST_FMT)), "malformed status item")

    `LPSC_ASSERT_HOLDS(a_ok_seen, i_clk, i_rst_n, !m_axis_tvalid || m_axis_tdata[1:0] != ST_OK || m_axis_tdata[4:2] <= 3'(MAX_SEGMENTS), "success reported with too many segments")

    `LPSC_ASSERT_AFTER_RESET(a_reset_idle, i_clk, i_rst_n, !m_axis_tvalid, "status item present after reset")

    `LPSC_ASSERT_HOLDS(a_pready, i_clk, i_rst_n, pready, "configuration port not ready")

endmodule

bind length_prefixed_segment_checker_unit lpsc_checker u_lpsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);

// File: test/length_prefixed_segment_checker_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Length-prefixed segment checker unit testbench
// Streams buffers of length-prefixed segments into the unit one byte item at a
// time, under several register settings, with random gaps on both streams and
// one long hold-off on the status side. Every accepted byte item goes through
// a parser model that predicts each status item (directed rows give their own),
// and each status item from the unit is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module length_prefixed_segment_checker_unit_tb;
    import lpsc_pkg::*;

    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic             typed;
        t_status          status;
        logic [SEG_W-1:0] seen;
    } t_row;

    // Starts from the reset settings: one segment, no length check.
    localparam t_row DIRECTED_ROWS [0:25] = '{
        '{8'h01, 1'b1, 1'b1, ST_FMT, 3'd0},
        '{8'h01, 1'b0, 1'b0, ST_OK,  3'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK,  3'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK,  3'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK,  3'd0},
        '{8'hAA, 1'b1, 1'b1, ST_OK,  3'd1},
        '{8'h00, 1'b0, 1'b0, ST_OK,  3'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK,  3'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK,  3'd0},
        '{8'h00, 1'b1, 1'b1, ST_FMT, 3'd1},
        '{8'h01, 1'b0, 1'b0, ST_OK,  3'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK,  3'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK,  3'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK,  3'd0},
        '{8'h55, 1'b0, 1'b0, ST_OK,  3'd0},
        '{8'h77, 1'b1, 1'b1, ST_FMT, 3'd1},
        '{8'h02, 1'b0, 1'b0, ST_OK,  3'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK,  3'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK,  3'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK,  3'd0},
        '{8'h11, 1'b1, 1'b1, ST_FMT, 3'd1},
        '{8'hFF, 1'b0, 1'b0, ST_OK,  3'd0},
        '{8'hFF, 1'b0, 1'b0, ST_OK,  3'd0},
        '{8'hFF, 1'b0, 1'b0, ST_OK,  3'd0},
        '{8'hFF, 1'b0, 1'b0, ST_OK,  3'd0},
        '{8'h00, 1'b1, 1'b1, ST_FMT, 3'd1}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;   // [7:0] data_byte
    logic              s_axis_tlast;   // last_byte
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [7:0]        m_axis_tdata;   // [1:0] status, [4:2] segments_seen
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic              item_typed;
    t_result           item_result;

    t_cfg              reg_shadow;
    t_phase            parse_phase;
    logic [PIDX_W-1:0] prefix_idx;
    logic [ACC_W-1:0]  len_acc;
    logic [31:0]       bytes_left;
    logic [SEG_W-1:0]  seg_seen;
    logic [TOTAL_W-1:0] byte_total;
    bit                fmt_bad;

    t_result           status_due_q [$];
    int                mismatch_count = 0;
    bit                hold_req = 1'b0;

    length_prefixed_segment_checker_unit i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic clear_parser;
        parse_phase = PH_PREFIX;
        prefix_idx  = '0;
        len_acc     = '0;
        bytes_left  = '0;
        seg_seen    = '0;
        byte_total  = '0;
        fmt_bad     = 1'b0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last,
                              output bit has_res, output t_result res);
        logic [31:0]      len;
        logic [SEG_W-1:0] idx;
        has_res = 1'b0;
        res     = '0;
        if (byte_total <= MAX_TOTAL_BYTES) byte_total++;
        case (parse_phase)
            PH_PREFIX: begin
                len_acc = len_acc | (ACC_W'(b) << (8 * prefix_idx));
                if (int'(prefix_idx) == PREFIX_BYTES - 1) begin
                    len        = len_acc;
                    idx        = seg_seen;
                    prefix_idx = '0;
                    len_acc    = '0;
                    if (seg_seen != '1) seg_seen++;
                    if (len == 0) fmt_bad = 1'b1;
                    if (reg_shadow.check_lengths && idx < MAX_SEGMENTS &&
                        32'(reg_shadow.exp_len[idx]) != len) fmt_bad = 1'b1;
                    bytes_left = len;
                    if (len == 0) begin
                        parse_phase = (seg_seen >= reg_shadow.seg_count) ? PH_DONE : PH_PREFIX;
                    end else begin
                        parse_phase = PH_BODY;
                    end
                end else begin
                    prefix_idx++;
                end
            end
            PH_BODY: begin
                if (bytes_left > 0) bytes_left--;
                if (bytes_left == 0) begin
                    parse_phase = (seg_seen >= reg_shadow.seg_count) ? PH_DONE : PH_PREFIX;
                end
            end
            default: begin
                fmt_bad = 1'b1;
            end
        endcase
        if (last) begin
            has_res = 1'b1;
            if (reg_shadow.seg_count == 0 || reg_shadow.seg_count > MAX_SEGMENTS ||
                byte_total > MAX_TOTAL_BYTES) begin
                res.status = ST_ARG;
            end else if (fmt_bad) begin
                res.status = ST_FMT;
            end else if (parse_phase == PH_PREFIX && prefix_idx != 0) begin
                res.status = ST_FMT;
            end else if (parse_phase == PH_BODY && bytes_left != 0) begin
                res.status = ST_FMT;
            end else begin
                res.status = ST_OK;
            end
            res.segments_seen = seg_seen;
            clear_parser();
        end
    endtask

    always @(posedge i_clk) begin : monitor
        bit      has_res;
        t_result res;
        t_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_byte(s_axis_tdata, s_axis_tlast, has_res, res);
                if (has_res) status_due_q.push_back(item_typed ? item_result : res);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (status_due_q.size() == 0) begin
                    $display("%0t: status item with none expected, got %0h",
                             $time, m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = status_due_q.pop_front();
                    if (m_axis_tdata[1:0] !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, m_axis_tdata[1:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[4:2] !== want.segments_seen) begin
                        $display("%0t: segments_seen expected %0d, got %0d",
                                 $time, want.segments_seen, m_axis_tdata[4:2]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin : status_sink
        int  run;
        int  pick;
        int  hold_left;
        bit  lvl;
        run           = 0;
        hold_left     = 0;
        lvl           = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (run == 0) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50) begin
                        lvl = 1'b1;
                        run = $urandom_range(1, 20);
                    end else if (pick < 90) begin
                        lvl = 1'b0;
                        run = $urandom_range(1, 3);
                    end else begin
                        lvl = 1'b0;
                        run = $urandom_range(10, 40);
                    end
                end
                run--;
                m_axis_tready <= lvl;
            end
        end
    end

    task automatic set_register(input logic [SEG_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SEG_COUNT: reg_shadow.seg_count     = value[SEG_W-1:0];
            REG_CHECK:     reg_shadow.check_lengths = value[0];
            default:       reg_shadow.exp_len[idx - REG_EXP_A] = value[LEN_W-1:0];
        endcase
    endtask

    task automatic apply_config(input t_cfg c);
        set_register(REG_SEG_COUNT, DATA_W'(c.seg_count));
        set_register(REG_CHECK, DATA_W'(c.check_lengths));
        for (int k = 0; k < MAX_SEGMENTS; k++) begin
            set_register(REG_EXP_A + SEG_W'(k), DATA_W'(c.exp_len[k]));
        end
    endtask

    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        while (status_due_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last, input bit steady,
                             input bit typed, input t_result fixed);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (steady) begin
            gap = ($urandom_range(0, 999) == 0) ? $urandom_range(10, 40) : 0;
        end else if (pick < 70) begin
            gap = 0;
        end else if (pick < 95) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        item_typed    <= typed;
        item_result   <= fixed;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly well-formed buffers for the current settings, some with a bad
    // length, a cut end or trailing bytes, and a few of pure noise.
    task automatic send_frame(input bit steady, output int n);
        logic [7:0]  bytes_q [$];
        logic [31:0] lens [MAX_SEGMENTS];
        int          nseg;
        int          pick;
        int          cap;
        int          k;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            repeat ($urandom_range(1, 12)) bytes_q.push_back(8'($urandom));
        end else begin
            if (reg_shadow.seg_count >= 1 && reg_shadow.seg_count <= MAX_SEGMENTS) begin
                nseg = reg_shadow.seg_count;
            end else begin
                nseg = $urandom_range(1, MAX_SEGMENTS);
            end
            if ($urandom_range(0, 9) == 0 && nseg > 1) nseg = $urandom_range(1, nseg - 1);
            for (k = 0; k < MAX_SEGMENTS; k++) begin
                if (reg_shadow.check_lengths && reg_shadow.exp_len[k] >= 1 &&
                    reg_shadow.exp_len[k] <= 24) begin
                    lens[k] = 32'(reg_shadow.exp_len[k]);
                end else begin
                    lens[k] = $urandom_range(1, 8);
                end
            end
            pick = $urandom_range(0, 99);
            k    = $urandom_range(0, nseg - 1);
            if (pick < 6) begin
                lens[k] = 0;
            end else if (pick < 12) begin
                lens[k] = lens[k] + 1;
            end else if (pick < 16) begin
                lens[k] = $urandom;
            end
            for (int s = 0; s < nseg; s++) begin
                for (int j = 0; j < PREFIX_BYTES; j++) bytes_q.push_back(lens[s][8*j +: 8]);
                cap = (lens[s] > 64) ? $urandom_range(0, 4) : int'(lens[s]);
                repeat (cap) bytes_q.push_back(8'($urandom));
            end
            pick = $urandom_range(0, 99);
            if (pick < 8 && bytes_q.size() > 1) begin
                repeat ($urandom_range(1, bytes_q.size() - 1)) void'(bytes_q.pop_back());
            end else if (pick < 15) begin
                repeat ($urandom_range(1, 3)) bytes_q.push_back(8'($urandom));
            end
        end
        n = bytes_q.size();
        foreach (bytes_q[i]) send_byte(bytes_q[i], i == n - 1, steady, 1'b0, '0);
    endtask

    task automatic send_long_frame(input logic [31:0] len);
        for (int j = 0; j < PREFIX_BYTES; j++) send_byte(len[8*j +: 8], 1'b0, 1'b1, 1'b0, '0);
        for (int i = 1; i <= int'(len); i++) begin
            send_byte(8'($urandom), i == int'(len), 1'b1, 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        t_cfg        c;
        t_result     fixed;
        int          items;
        int          sent;
        int          got;
        int          pick;
        logic [31:0] long_lens [3];
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        item_typed    = 1'b0;
        item_result   = '0;
        clear_parser();
        reg_shadow.seg_count     = SEG_W'(1);
        reg_shadow.check_lengths = 1'b0;
        for (int k = 0; k < MAX_SEGMENTS; k++) reg_shadow.exp_len[k] = LEN_W'(1);
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i]) begin
            fixed.status        = DIRECTED_ROWS[i].status;
            fixed.segments_seen = DIRECTED_ROWS[i].seen;
            send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last, 1'b0,
                      DIRECTED_ROWS[i].typed, fixed);
        end

        items = 0;
        for (int ph = 0; items < 1500; ph++) begin
            drain_results();
            if (ph == 0) begin
                c.seg_count = SEG_W'(0);
            end else if (ph == 1) begin
                c.seg_count = SEG_W'(7);
            end else if (ph == 2) begin
                c.seg_count = SEG_W'(MAX_SEGMENTS);
            end else if ($urandom_range(0, 9) < 8) begin
                c.seg_count = SEG_W'($urandom_range(1, MAX_SEGMENTS));
            end else begin
                c.seg_count = SEG_W'($urandom_range(0, 7));
            end
            c.check_lengths = (ph == 2) ? 1'b1 : 1'($urandom_range(0, 1));
            for (int k = 0; k < MAX_SEGMENTS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    c.exp_len[k] = LEN_W'($urandom_range(1, 8));
                end else if (pick < 93) begin
                    c.exp_len[k] = LEN_W'(MAX_TOTAL_BYTES);
                end else begin
                    c.exp_len[k] = LEN_W'($urandom_range(0, 2**LEN_W - 1));
                end
            end
            apply_config(c);
            if (ph == 3) begin
                hold_req = 1'b1;
                repeat (60) send_byte(8'($urandom), 1'b1, 1'b1, 1'b0, '0);
                items += 60;
            end
            sent = 0;
            while (sent < 120) begin
                send_frame($urandom_range(0, 4) == 0, got);
                sent += got;
            end
            items += sent;
        end

        // Totals at, one byte over and four bytes over the byte limit.
        long_lens = '{MAX_TOTAL_BYTES - 4, MAX_TOTAL_BYTES - 3, MAX_TOTAL_BYTES};
        foreach (long_lens[i]) begin
            drain_results();
            c.seg_count     = SEG_W'(1);
            c.check_lengths = 1'b1;
            for (int k = 0; k < MAX_SEGMENTS; k++) c.exp_len[k] = LEN_W'(1);
            c.exp_len[0] = long_lens[i][LEN_W-1:0];
            apply_config(c);
            send_long_frame(long_lens[i]);
        end

        drain_results();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
